### design/arp_cache_responder_top_macros.svh
// ----------------------------------------------------------------------------
// ARP cache responder assertion macros
// Concurrent assertion wrappers used by the top-level design file of the block.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_RESPONDER_TOP_MACROS_SVH
`define ARP_CACHE_RESPONDER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ARPC_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("arpc: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ARPC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("arpc: assertion failed");

`else

`define ARPC_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ARPC_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

### design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache responder package
// Shared types and codes of the ARP cache responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int unsigned IP_W     = 32;
    localparam int unsigned MAC_W    = 48;
    localparam int unsigned OPCODE_W = 16;

    // Item kinds carried on the input tuser.
    localparam logic OP_ARP     = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    localparam logic [OPCODE_W-1:0] ARP_OPCODE_REQUEST = 16'd1;
    localparam logic [OPCODE_W-1:0] ARP_OPCODE_REPLY   = 16'd2;

    // Configuration register indexes.
    localparam logic CFG_OWN_IP  = 1'b0;
    localparam logic CFG_OWN_MAC = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } arpc_state_t;

endpackage

### design/arpc_table.sv
// ----------------------------------------------------------------------------
// ARP cache table
// One-write, one-read synchronous memory of IP/MAC entries, registered read.
// ----------------------------------------------------------------------------
module arpc_table #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  arpc_pkg::entry_t wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output arpc_pkg::entry_t rdata
);

    arpc_pkg::entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/arp_cache_responder_top.sv
// ----------------------------------------------------------------------------
// ARP cache responder
// Learns senders of ARP packets aimed at this interface and resolves IPs.
// ----------------------------------------------------------------------------
// Input stream (s_*): s_tuser selects the item kind, 0 for a received ARP
// packet and 1 for a resolve query. Every input transaction yields exactly
// one output transaction on m_*. Own IP is set through the cfg_* port while
// the block is idle; the user must keep to this, as the block does not
// enforce it. The own MAC register is accepted but only the frame builder
// downstream uses it, so it is not kept here. Entries are learned in order
// into a single-port-read table, so a fill count stands in for per-entry
// valid marks and no clearing pass is needed.
// A received ARP packet passes from the idle state through the emit state
// into the output register. A resolve query reads one entry per cycle from
// the table and finishes once the first matching entry is read, or once
// all filled entries are read on a miss. One item is in work at a time; the
// next one is accepted as soon as the current result moves to the output
// register, even while it waits for m_tready.
// Reset empties the table (fill count to zero) and clears own IP. A stalled
// receiver holds the result in the output register and, once a second
// result is ready, holds off the input stream.
// ----------------------------------------------------------------------------
`include "arp_cache_responder_top_macros.svh"

module arp_cache_responder_top #(
    parameter int ENTRIES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [47:0]  cfg_wdata,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: arp_opcode[15:0], src_ip[47:16], sender_mac[95:48],
    //          tgt_ip[127:96], query_ip[159:128]
    input  logic [159:0] s_tdata,
    // s_tuser: operation[0]
    input  logic         s_tuser,
    // Output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: reply_dest_mac[47:0], reply_dest_ip[79:48], resolved_mac[127:80]
    output logic [127:0] m_tdata,
    // m_tuser: reply_due[0], hit[1]
    output logic [1:0]   m_tuser
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    // Input field views
    logic [15:0] in_opcode;
    logic [31:0] in_src_ip;
    logic [47:0] in_sender_mac;
    logic [31:0] in_tgt_ip;
    logic [31:0] in_query_ip;

    assign in_opcode     = s_tdata[15:0];
    assign in_src_ip     = s_tdata[47:16];
    assign in_sender_mac = s_tdata[95:48];
    assign in_tgt_ip     = s_tdata[127:96];
    assign in_query_ip   = s_tdata[159:128];

    arpc_pkg::arpc_state_t state_reg, state_next;

    logic [31:0]   own_ip_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          data_valid_reg, data_valid_next;
    logic [31:0]   query_ip_reg, query_ip_next;

    // Staged result of the item in work
    logic          res_reply_due_reg, res_reply_due_next;
    logic [47:0]   res_dest_mac_reg, res_dest_mac_next;
    logic [31:0]   res_dest_ip_reg, res_dest_ip_next;
    logic          res_hit_reg, res_hit_next;
    logic [47:0]   res_rmac_reg, res_rmac_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic          out_reply_due_reg;
    logic [47:0]   out_dest_mac_reg;
    logic [31:0]   out_dest_ip_reg;
    logic          out_hit_reg;
    logic [47:0]   out_rmac_reg;
    logic          out_load;

    logic             mem_we;
    logic             mem_re;
    arpc_pkg::entry_t mem_wdata;
    arpc_pkg::entry_t mem_rdata;
    logic             accept;
    logic             out_free;
    logic             match;
    logic             scanning;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign match     = data_valid_reg && (mem_rdata.ip == query_ip_reg);
    assign mem_wdata = '{ip: in_src_ip, mac: in_sender_mac};
    assign scanning  = (state_reg == arpc_pkg::ST_SCAN);

    arpc_table #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                arpc_pkg::CFG_OWN_IP:  own_ip_reg <= cfg_wdata[31:0];
                default:               own_ip_reg <= own_ip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= arpc_pkg::ST_IDLE;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            data_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            data_valid_reg <= data_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_ip_reg      <= query_ip_next;
        res_reply_due_reg <= res_reply_due_next;
        res_dest_mac_reg  <= res_dest_mac_next;
        res_dest_ip_reg   <= res_dest_ip_next;
        res_hit_reg       <= res_hit_next;
        res_rmac_reg      <= res_rmac_next;
        if (out_load)
        begin
            out_reply_due_reg <= res_reply_due_reg;
            out_dest_mac_reg  <= res_dest_mac_reg;
            out_dest_ip_reg   <= res_dest_ip_reg;
            out_hit_reg       <= res_hit_reg;
            out_rmac_reg      <= res_rmac_reg;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        scan_idx_next      = scan_idx_reg;
        data_valid_next    = 1'b0;
        query_ip_next      = query_ip_reg;
        res_reply_due_next = res_reply_due_reg;
        res_dest_mac_next  = res_dest_mac_reg;
        res_dest_ip_next   = res_dest_ip_reg;
        res_hit_next       = res_hit_reg;
        res_rmac_next      = res_rmac_reg;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        out_load           = 1'b0;
        s_tready           = 1'b0;

        unique case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    res_reply_due_next = 1'b0;
                    res_dest_mac_next  = '0;
                    res_dest_ip_next   = '0;
                    res_hit_next       = 1'b0;
                    res_rmac_next      = '0;
                    state_next         = arpc_pkg::ST_EMIT;
                    if (s_tuser == arpc_pkg::OP_RESOLVE)
                    begin
                        query_ip_next = in_query_ip;
                        scan_idx_next = '0;
                        if (count_reg != '0)
                        begin
                            state_next = arpc_pkg::ST_SCAN;
                        end
                    end
                    else if (in_tgt_ip == own_ip_reg)
                    begin
                        // Entries fill in order, so the fill count is the
                        // lowest free entry.
                        if (count_reg < FULL_COUNT)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        if (in_opcode == arpc_pkg::ARP_OPCODE_REQUEST)
                        begin
                            res_reply_due_next = 1'b1;
                            res_dest_mac_next  = in_sender_mac;
                            res_dest_ip_next   = in_src_ip;
                        end
                    end
                end
            end

            arpc_pkg::ST_SCAN:
            begin
                // Reads are issued back to back; each compare comes in the cycle after its read.
                if (match)
                begin
                    res_hit_next  = 1'b1;
                    res_rmac_next = mem_rdata.mac;
                    state_next    = arpc_pkg::ST_EMIT;
                end
                else
                begin
                    if (scan_idx_reg < count_reg)
                    begin
                        mem_re          = 1'b1;
                        scan_idx_next   = scan_idx_reg + CW'(1);
                        data_valid_next = 1'b1;
                    end
                    else if (data_valid_reg)
                    begin
                        state_next = arpc_pkg::ST_EMIT;
                    end
                end
            end

            arpc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = arpc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rmac_reg, out_dest_ip_reg, out_dest_mac_reg};
    assign m_tuser  = {out_hit_reg, out_reply_due_reg};

    `ARPC_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_COUNT)
    `ARPC_ASSERT_NEXT(a_count_stable_scan, clk, rst_n, scanning, $stable(count_reg))
    `ARPC_ASSERT_IMPLIES(a_scan_in_range, clk, rst_n, scanning, scan_idx_reg <= count_reg)
    `ARPC_ASSERT_IMPLIES(a_hit_no_reply, clk, rst_n, out_valid_reg, !(out_hit_reg && out_reply_due_reg))
    `ARPC_ASSERT_IMPLIES(a_read_only_scan, clk, rst_n, data_valid_reg, scanning)

endmodule

### test/arp_cache_responder_top_test.sv
// ----------------------------------------------------------------------------
// ARP cache responder testbench
// Drives received ARP packets and resolve queries into the block, keeps its
// own copy of the ARP table and own IP, and checks every output transaction
// field by field against the predicted result, under random idling on both
// streams, a long receiver hold-off and a full table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_cache_responder_top_test;

    localparam int ENTRIES = 64;

    typedef struct {
        logic                          op;
        logic [arpc_pkg::OPCODE_W-1:0] opcode;
        logic [arpc_pkg::IP_W-1:0]     src_ip;
        logic [arpc_pkg::MAC_W-1:0]    sender_mac;
        logic [arpc_pkg::IP_W-1:0]     tgt_ip;
        logic [arpc_pkg::IP_W-1:0]     query_ip;
    } arp_item_t;

    typedef struct {
        logic                       reply_due;
        logic [arpc_pkg::MAC_W-1:0] reply_dest_mac;
        logic [arpc_pkg::IP_W-1:0]  reply_dest_ip;
        logic                       hit;
        logic [arpc_pkg::MAC_W-1:0] resolved_mac;
    } arp_result_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic         cfg_index;
    logic [47:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    // Shadow copy of the block's table and registers.
    logic [arpc_pkg::IP_W-1:0]  cache_ip [ENTRIES];
    logic [arpc_pkg::MAC_W-1:0] cache_mac [ENTRIES];
    logic                       cache_valid [ENTRIES];
    int                         cache_fill;
    logic [arpc_pkg::IP_W-1:0]  own_ip_q;
    logic [arpc_pkg::MAC_W-1:0] own_mac_q;

    arp_result_t                pending_results [$];
    logic [arpc_pkg::IP_W-1:0]  ip_pool [8];
    int                         errors;
    bit                         no_idle;
    bit                         hold_start;
    int                         hold_len;

    arp_cache_responder_top #(
        .ENTRIES(ENTRIES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("arp_cache_responder_top test failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(0, 2);
        else if (roll < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[arpc_pkg::MAC_W-1:0];
    endfunction

    function automatic bit ip_learned(logic [arpc_pkg::IP_W-1:0] ip);
        bit found;
        found = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (cache_valid[i] && cache_ip[i] == ip)
                found = 1;
        return found;
    endfunction

    // Computes the result of one accepted item and updates the shadow table.
    function automatic arp_result_t learn_or_resolve(arp_item_t it);
        arp_result_t r;
        bit          done;
        r.reply_due      = 1'b0;
        r.reply_dest_mac = '0;
        r.reply_dest_ip  = '0;
        r.hit            = 1'b0;
        r.resolved_mac   = '0;
        done             = 0;
        if (it.op == arpc_pkg::OP_ARP)
        begin
            if (it.tgt_ip == own_ip_q)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!done && !cache_valid[i])
                    begin
                        cache_ip[i]    = it.src_ip;
                        cache_mac[i]   = it.sender_mac;
                        cache_valid[i] = 1'b1;
                        cache_fill++;
                        done = 1;
                    end
                end
                if (it.opcode == arpc_pkg::ARP_OPCODE_REQUEST)
                begin
                    r.reply_due      = 1'b1;
                    r.reply_dest_mac = it.sender_mac;
                    r.reply_dest_ip  = it.src_ip;
                end
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!done && cache_valid[i] && cache_ip[i] == it.query_ip)
                begin
                    r.hit          = 1'b1;
                    r.resolved_mac = cache_mac[i];
                    done = 1;
                end
            end
        end
        return r;
    endfunction

    // One input transaction; the expectation is queued when it is accepted.
    task automatic send_item(arp_item_t it);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = it.op;
        s_tdata  = {it.query_ip, it.tgt_ip, it.sender_mac, it.src_ip, it.opcode};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(learn_or_resolve(it));
    endtask

    task automatic send_arp(logic [arpc_pkg::OPCODE_W-1:0] opcode,
                            logic [arpc_pkg::IP_W-1:0] sip,
                            logic [arpc_pkg::MAC_W-1:0] smac,
                            logic [arpc_pkg::IP_W-1:0] tip);
        arp_item_t it;
        it.op         = arpc_pkg::OP_ARP;
        it.opcode     = opcode;
        it.src_ip     = sip;
        it.sender_mac = smac;
        it.tgt_ip     = tip;
        it.query_ip   = $urandom();
        send_item(it);
    endtask

    task automatic send_resolve(logic [arpc_pkg::IP_W-1:0] qip);
        arp_item_t it;
        it.op         = arpc_pkg::OP_RESOLVE;
        it.opcode     = 16'($urandom());
        it.src_ip     = $urandom();
        it.sender_mac = rand_mac();
        it.tgt_ip     = $urandom();
        it.query_ip   = qip;
        send_item(it);
    endtask

    // Drops s_tvalid and waits until every queued result has been taken.
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [47:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == arpc_pkg::CFG_OWN_IP)
            own_ip_q = value[arpc_pkg::IP_W-1:0];
        else
            own_mac_q = value;
    endtask

    function automatic arp_item_t make_random(int match_pct);
        arp_item_t it;
        it.op         = ($urandom_range(0, 99) < 45) ? arpc_pkg::OP_ARP : arpc_pkg::OP_RESOLVE;
        it.opcode     = 16'($urandom());
        it.src_ip     = $urandom();
        it.sender_mac = rand_mac();
        it.tgt_ip     = $urandom();
        it.query_ip   = $urandom();
        if (it.op == arpc_pkg::OP_ARP)
        begin
            if ($urandom_range(0, 99) < match_pct)
                it.tgt_ip = own_ip_q;
            else if ($urandom_range(0, 1) == 0)
                it.tgt_ip = own_ip_q ^ (32'h1 << $urandom_range(0, 31));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: it.opcode = arpc_pkg::ARP_OPCODE_REQUEST;
                5, 6:          it.opcode = arpc_pkg::ARP_OPCODE_REPLY;
                default:       ;
            endcase
            if ($urandom_range(0, 1) == 0)
                it.src_ip = ip_pool[$urandom_range(0, 7)];
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    if (cache_fill > 0)
                        it.query_ip = cache_ip[$urandom_range(0, cache_fill - 1)];
                5, 6:
                    it.query_ip = ip_pool[$urandom_range(0, 7)];
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic test_directed();
        // Own IP is still at its reset value of zero here.
        send_resolve(32'h0);
        send_arp(arpc_pkg::ARP_OPCODE_REQUEST, 32'h1234_5678, 48'h0000_0000_00AA,
                 32'h0000_0001);
        send_resolve(32'h1234_5678);
        send_arp(arpc_pkg::ARP_OPCODE_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0);
        send_arp(arpc_pkg::ARP_OPCODE_REPLY, 32'h0, 48'h0, 32'h0);
        send_arp(16'd0, 32'hC0A8_0001, 48'h0200_0000_0001, 32'h0);
        send_arp(16'hFFFF, 32'h0A00_0002, 48'h0200_0000_0002, 32'h0);
        send_resolve(32'hFFFF_FFFF);
        send_resolve(32'h0);
        send_resolve(32'h0A00_0002);
        // A duplicate sender takes a second entry; the first one still wins.
        send_arp(arpc_pkg::ARP_OPCODE_REQUEST, 32'hFFFF_FFFF, 48'h0123_4567_89AB, 32'h0);
        send_resolve(32'hFFFF_FFFF);
        send_resolve(32'hDEAD_BEEF);
        drain();
        write_reg(arpc_pkg::CFG_OWN_IP, 48'h0000_FFFF_FFFF);
        write_reg(arpc_pkg::CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        send_arp(16'd0, 32'hDEAD_BEEF, 48'hAAAA_5555_AAAA, 32'h0);
        send_arp(arpc_pkg::ARP_OPCODE_REQUEST, 32'hDEAD_BEEF, 48'h5555_AAAA_5555,
                 32'hFFFF_FFFF);
        send_arp(arpc_pkg::ARP_OPCODE_REQUEST, 32'h8000_0000, 48'h8000_0000_0000,
                 32'h7FFF_FFFF);
        send_resolve(32'hDEAD_BEEF);
        send_resolve(32'h8000_0000);
        drain();
    endtask

    task automatic test_random();
        logic [arpc_pkg::IP_W-1:0] phase_ip [5];
        int                        match_pct [5];
        logic [47:0]               phase_mac;
        phase_ip  = '{32'h0, $urandom(), 32'hFFFF_FFFF, $urandom(), 32'h0A00_0001};
        match_pct = '{10, 30, 40, 25, 50};
        for (int p = 0; p < 5; p++)
        begin
            phase_mac = (p == 0) ? 48'h0 : rand_mac();
            write_reg(arpc_pkg::CFG_OWN_IP, {16'h0, phase_ip[p]});
            write_reg(arpc_pkg::CFG_OWN_MAC, phase_mac);
            foreach (ip_pool[i])
                ip_pool[i] = $urandom();
            ip_pool[0] = own_ip_q;
            no_idle = (p == 2);
            repeat (290)
                send_item(make_random(match_pct[p]));
            drain();
            no_idle = 0;
        end
    endtask

    // The receiver stalls for a long time while items keep coming.
    task automatic test_hold_off();
        hold_len   = 300;
        hold_start = 1'b1;
        no_idle    = 1;
        repeat (25)
            send_item(make_random(30));
        no_idle = 0;
        drain();
    endtask

    task automatic test_table_full();
        logic [arpc_pkg::IP_W-1:0] fresh_ip;
        while (cache_fill < ENTRIES)
            send_arp($urandom_range(0, 1) ? arpc_pkg::ARP_OPCODE_REQUEST
                                          : arpc_pkg::ARP_OPCODE_REPLY,
                     $urandom(), rand_mac(), own_ip_q);
        do
            fresh_ip = $urandom();
        while (ip_learned(fresh_ip));
        // With no free entry the sender is dropped but a request is answered.
        send_arp(arpc_pkg::ARP_OPCODE_REQUEST, fresh_ip, rand_mac(), own_ip_q);
        send_arp(arpc_pkg::ARP_OPCODE_REPLY, fresh_ip, rand_mac(), own_ip_q);
        send_resolve(fresh_ip);
        send_resolve(cache_ip[ENTRIES - 1]);
        send_resolve(cache_ip[0]);
        repeat (20)
            send_item(make_random(50));
        drain();
    endtask

    // Receiver side: random stalls, plus a long hold-off on request.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_start)
            begin
                hold_left  = hold_len;
                hold_start = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (no_idle)
                m_tready = 1'b1;
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        arp_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("output transaction with no result expected");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("reply_due", 64'(want.reply_due), 64'(m_tuser[0]));
                check_field("hit", 64'(want.hit), 64'(m_tuser[1]));
                check_field("reply_dest_mac", 64'(want.reply_dest_mac),
                            64'(m_tdata[47:0]));
                check_field("reply_dest_ip", 64'(want.reply_dest_ip),
                            64'(m_tdata[79:48]));
                check_field("resolved_mac", 64'(want.resolved_mac),
                            64'(m_tdata[127:80]));
            end
        end
    end

    initial
    begin
        errors     = 0;
        no_idle    = 0;
        hold_start = 1'b0;
        hold_len   = 0;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = arpc_pkg::CFG_OWN_IP;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = arpc_pkg::OP_ARP;
        own_ip_q   = '0;
        own_mac_q  = '0;
        cache_fill = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            cache_ip[i]    = '0;
            cache_mac[i]   = '0;
            cache_valid[i] = 1'b0;
        end
        foreach (ip_pool[i])
            ip_pool[i] = $urandom();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random();
        test_hold_off();
        test_table_full();

        drain();
        repeat (ENTRIES + 10) @(posedge clk);
        if (errors == 0)
            $display("arp_cache_responder_top test passed");
        else
            $display("arp_cache_responder_top test failed");
        $finish;
    end

endmodule
